FILE: rtl/core/mrpt_pkg.sv
`default_nettype none
package mrpt_pkg;

    localparam int CAND_W  = 32;
    localparam int LIMIT_W = 33;
    localparam int BASE_W  = 6;

    typedef logic [CAND_W-1:0]  t_word;
    typedef logic [LIMIT_W-1:0] t_limit;
    typedef logic [BASE_W-1:0]  t_base;

    localparam t_limit LIMIT_RESET = 33'h0_8000_0000;

    // request to the shared modular multiplier
    typedef struct packed {
        logic  start;
        t_word a;
        t_word b;
    } t_mm_req;

    // status back from it
    typedef struct packed {
        logic  busy;
        logic  done;
        t_word res;
    } t_mm_rsp;

    // witness bases: {2,7,61} for narrow builds, primes 2..29 for wide ones
    function automatic t_base base_of(input logic wide, input logic [3:0] idx);
        t_base b;
        b = 6'd2;
        if (!wide) begin
            case (idx)
                4'd0:    b = 6'd2;
                4'd1:    b = 6'd7;
                4'd2:    b = 6'd61;
                default: b = 6'd2;
            endcase
        end else begin
            case (idx)
                4'd0:    b = 6'd2;
                4'd1:    b = 6'd3;
                4'd2:    b = 6'd5;
                4'd3:    b = 6'd7;
                4'd4:    b = 6'd11;
                4'd5:    b = 6'd13;
                4'd6:    b = 6'd17;
                4'd7:    b = 6'd19;
                4'd8:    b = 6'd23;
                4'd9:    b = 6'd29;
                default: b = 6'd2;
            endcase
        end
        return b;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/mrpt_ifs.sv
`default_nettype none
interface mrpt_cand_if;
    import mrpt_pkg::*;
    logic  valid;
    logic  ready;
    t_word candidate;
    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface mrpt_res_if;
    logic valid;
    logic ready;
    logic is_prime;
    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

interface mrpt_cfg_if;
    import mrpt_pkg::*;
    logic   valid;
    logic   ready;
    t_limit small_limit;
    modport source (output valid, output small_limit, input ready);
    modport sink   (input valid, input small_limit, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/mrpt_modmul.sv
`default_nettype none
// a*b mod m: a multiply, then one remainder bit per cycle
module mrpt_modmul
    import mrpt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_mm_req i_req,
    input  wire t_word   i_mod,
    output t_mm_rsp      o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [4:0]        r_cnt;
    t_word             r_rem;
    t_word             r_lo;
    logic [CAND_W:0]   trial;
    logic [CAND_W:0]   diff;

    // high half of a product of reduced operands is already below m
    assign trial = {r_rem, r_lo[CAND_W-1]};
    assign diff  = trial - {1'b0, i_mod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            {r_rem, r_lo} <= {{CAND_W{1'b0}}, i_req.a} * {{CAND_W{1'b0}}, i_req.b};
        end else if (r_busy) begin
            r_rem <= diff[CAND_W] ? trial[CAND_W-1:0] : diff[CAND_W-1:0];
            r_lo  <= {r_lo[CAND_W-2:0], 1'b0};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_rem;

endmodule
`default_nettype wire

FILE: rtl/core/miller_rabin_prime_test.sv
`default_nettype none
// Channel   Dir  Payload              Notes
// i_cfg     in   small_limit[32:0]    always ready; write only when idle
// i_cand    in   candidate[31:0]      ready only while the test engine is idle
// o_res     out  is_prime             held in an output register until taken
//
// Even, below-limit and unit candidates go from idle straight to the final state. Otherwise
// the trailing-zero scan of m-1 runs first, then each base runs a square-and-
// multiply plus up to s-1 squarings, every step one pass of the shared modmul (an
// issue, a multiply, then 32 remainder bits). Reset is synchronous, active low, and
// clears the control state and sets small_limit to 2^31. A stalled result sink holds
// the engine in its final state; the next word is taken once the result is registered.
module miller_rabin_prime_test
    import mrpt_pkg::*;
#(
    parameter int NUMBER_BITS = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mrpt_cfg_if.sink    i_cfg,
    mrpt_cand_if.sink   i_cand,
    mrpt_res_if.source  o_res
);

    localparam logic       WIDE  = (NUMBER_BITS > 32);
    localparam logic [3:0] LAST  = WIDE ? 4'd9 : 4'd2;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TZ   = 4'd1;   // count trailing zeros of m-1
    localparam logic [3:0] S_BASE = 4'd2;   // set up next witness
    localparam logic [3:0] S_EXP  = 4'd3;   // a^e, msb first
    localparam logic [3:0] S_EXPW = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_SQ   = 4'd6;   // squaring chain looking for m-1
    localparam logic [3:0] S_SQW  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0] r_state;
    t_limit     r_limit;
    t_word      r_m;
    t_word      r_sh;
    logic [4:0] r_s;
    logic [4:0] r_bit;
    logic [4:0] r_rcnt;
    logic [3:0] r_idx;
    t_word      r_acc;
    logic       r_started;
    logic       r_phase;    // 0: square step, 1: multiply step
    logic       r_res;
    logic       r_ov;
    logic       r_op;

    t_word      m_minus1;
    t_word      base_w;
    t_mm_req    mm_req;
    t_mm_rsp    mm_rsp;

    assign m_minus1 = r_m - 32'd1;
    assign base_w   = {{(CAND_W-BASE_W){1'b0}}, base_of(WIDE, r_idx)};

    assign i_cfg.ready  = 1'b1;
    assign i_cand.ready = (r_state == S_IDLE);
    assign o_res.valid    = r_ov;
    assign o_res.is_prime = r_op;

    mrpt_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mm_req),
        .i_mod   (r_m),
        .o_rsp   (mm_rsp)
    );

    // operand choice: multiply step uses the base, all others square
    always_comb begin
        mm_req.start = 1'b0;
        mm_req.a     = r_acc;
        mm_req.b     = r_acc;
        case (r_state)
            S_EXP: begin
                if (!r_phase) begin
                    mm_req.start = r_started;
                end else begin
                    mm_req.start = m_minus1[r_bit];
                    mm_req.b     = base_w;
                end
            end
            S_SQ: begin
                // the last square of the chain is never checked, so skip it
                mm_req.start = (r_acc != m_minus1) && (r_rcnt != r_s - 5'd1);
            end
            default: mm_req.start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_limit <= LIMIT_RESET;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_limit <= i_cfg.small_limit;
            end
            // S_DONE handles the output register itself
            if (r_ov && o_res.ready && (r_state != S_DONE)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cand.valid) begin
                        r_m   <= i_cand.candidate;
                        r_sh  <= i_cand.candidate - 32'd1;
                        r_s   <= '0;
                        r_idx <= '0;
                        if (!i_cand.candidate[0]) begin
                            r_res   <= 1'b0;
                            r_state <= S_DONE;
                        end else if ({1'b0, i_cand.candidate} < r_limit) begin
                            r_res   <= 1'b1;
                            r_state <= S_DONE;
                        end else if (i_cand.candidate == 32'd1) begin
                            r_res   <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_TZ;
                        end
                    end
                end
                S_TZ: begin
                    if (!r_sh[0]) begin
                        r_sh <= {1'b0, r_sh[CAND_W-1:1]};
                        r_s  <= r_s + 5'd1;
                    end else begin
                        r_state <= S_BASE;
                    end
                end
                S_BASE: begin
                    r_acc     <= 32'd1;
                    r_started <= 1'b0;
                    r_phase   <= 1'b0;
                    r_bit     <= 5'd31;
                    if (base_w == r_m) begin
                        if (r_idx == LAST) begin
                            r_res   <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_idx <= r_idx + 4'd1;
                        end
                    end else begin
                        r_state <= S_EXP;
                    end
                end
                S_EXP: begin
                    if (!r_phase) begin
                        if (r_started) begin
                            r_state <= S_EXPW;
                        end else begin
                            r_phase <= 1'b1;
                        end
                    end else if (m_minus1[r_bit]) begin
                        r_started <= 1'b1;
                        r_state   <= S_EXPW;
                    end else begin
                        r_bit   <= r_bit - 5'd1;
                        r_phase <= 1'b0;
                    end
                end
                S_EXPW: begin
                    if (mm_rsp.done) begin
                        r_acc <= mm_rsp.res;
                        if (!r_phase) begin
                            r_phase <= 1'b1;
                            r_state <= S_EXP;
                        end else if (r_bit == r_s) begin
                            // bit s of m-1 is always set, so the exponent ends here
                            r_state <= S_CHK;
                        end else begin
                            r_bit   <= r_bit - 5'd1;
                            r_phase <= 1'b0;
                            r_state <= S_EXP;
                        end
                    end
                end
                S_CHK: begin
                    r_rcnt <= '0;
                    if (r_acc == 32'd1) begin
                        if (r_idx == LAST) begin
                            r_res   <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_idx   <= r_idx + 4'd1;
                            r_state <= S_BASE;
                        end
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    // values a^(e*2^r) for r = 0 .. s-1 are checked against m-1
                    if (r_acc == m_minus1) begin
                        if (r_idx == LAST) begin
                            r_res   <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_idx   <= r_idx + 4'd1;
                            r_state <= S_BASE;
                        end
                    end else if (r_rcnt == r_s - 5'd1) begin
                        r_res   <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SQW;
                    end
                end
                S_SQW: begin
                    if (mm_rsp.done) begin
                        r_acc   <= mm_rsp.res;
                        r_rcnt  <= r_rcnt + 5'd1;
                        r_state <= S_SQ;
                    end
                end
                S_DONE: begin
                    if (!r_ov || o_res.ready) begin
                        r_op    <= r_res;
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_mm_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_req.start |-> !mm_rsp.busy)
        else $error("modmul started while busy");

    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ) |-> (r_acc < r_m))
        else $error("accumulator not reduced");

    a_rcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ) |-> (r_rcnt <= r_s))
        else $error("squaring count past s");

    a_wait_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_EXPW) |-> mm_rsp.busy)
        else $error("waiting with idle modmul");
`endif

endmodule
`default_nettype wire
